[rtl/bole_pkg.sv]
`timescale 1ns / 1ps
package bole_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int LEN_W        = 7;
	localparam int DATA_W       = 32;

	typedef enum logic [3:0] {
		CMD_SET    = 4'd0,
		CMD_FRONT  = 4'd1,
		CMD_END    = 4'd2,
		CMD_AFTER  = 4'd3,
		CMD_BEFORE = 4'd4,
		CMD_DEL    = 4'd5,
		CMD_REV    = 4'd6,
		CMD_SEARCH = 4'd7,
		CMD_READ   = 4'd8
	} cmd_e;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY,
		ST_READ
	} state_e;

	// per-cell operation on the stored element
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SET0,
		OP_INS,
		OP_DEL,
		OP_ROT_DN,
		OP_ROT_UP
	} cell_op_e;

	// which cells sit at or above the insert/delete position
	typedef enum logic [2:0] {
		GE_ALL,
		GE_TAIL,
		GE_PRE,
		GE_PRE_INCL,
		GE_NSUF,
		GE_NSUF_INCL
	} ge_sel_e;

	typedef struct packed {
		cell_op_e           op;
		ge_sel_e            ge_sel;
		logic [DATA_W-1:0]  value;
		logic [DATA_W-1:0]  wrap;
		logic [LEN_W-1:0]   len;
	} cell_ctl_t;

	typedef struct packed {
		logic [3:0]          cmd;
		logic signed [31:0]  value;
		logic signed [31:0]  key;
	} in_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                found;
		logic [6:0]          count;
		logic signed [31:0]  element;
		logic                last_of_run;
	} out_t;

endpackage

[rtl/bounded_ordered_list_engine_top.sv]
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one element per cell, with a reverse flag instead of moving data on reverse.
// A command is accepted into a held register. Then every cell compares its
// element with the key or value and registers the match. Then the match
// summaries ripple along the row, all cells shift at once and the result
// beat is registered, held off while the output stalls. A read out then gives
// one beat per cycle while the receiver takes them, rotating the row by one
// cell per element. Input is taken only between commands; the result register
// frees the input side while the last beat waits to be taken.
module bounded_ordered_list_engine_top #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bole_pkg::in_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bole_pkg::out_t out_data
);

	localparam int LW = bole_pkg::LEN_W;
	localparam int DW = bole_pkg::DATA_W;

	bole_pkg::state_e     state_q, state_nx;
	bole_pkg::in_t        cmd_q;
	logic [LW-1:0]        len_q, len_nx;
	logic                 rev_q, rev_nx;
	logic [LW-1:0]        cnt_q;
	logic                 out_valid_q;
	bole_pkg::out_t       out_q, res;
	logic                 emit;
	logic                 can_emit;
	bole_pkg::cell_ctl_t  ctl;
	logic [DW-1:0]        cmp_x;
	logic [DW-1:0]        head, tail;
	logic                 any_match;
	logic                 empty, full;

	logic [DW-1:0]        elem_w [CAPACITY];
	logic                 ge_w   [CAPACITY];
	logic                 pre_w  [CAPACITY];
	logic                 suf_w  [CAPACITY];

	assign empty     = len_q == '0;
	assign full      = len_q >= LW'(CAPACITY);
	assign can_emit  = !out_valid_q || out_ready;
	assign in_ready  = state_q == bole_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign head      = elem_w[0];
	assign any_match = pre_w[CAPACITY-1];
	assign cmp_x     = (cmd_q.cmd == bole_pkg::CMD_AFTER || cmd_q.cmd == bole_pkg::CMD_BEFORE)
		? cmd_q.key : cmd_q.value;

	// pick the element of the last occupied cell
	always_comb begin
		tail = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail = tail | (elem_w[i] & {DW{len_q == LW'(i + 1)}});
		end
	end

	// row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		bole_cell #(.IDX(g)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cmp_x     (cmp_x),
			.left_elem ((g == 0) ? '0 : elem_w[(g == 0) ? 0 : g - 1]),
			.left_ge   ((g == 0) ? 1'b0 : ge_w[(g == 0) ? 0 : g - 1]),
			.right_elem((g == CAPACITY - 1) ? elem_w[g] : elem_w[(g == CAPACITY - 1) ? g : g + 1]),
			.pre_in    ((g == 0) ? 1'b0 : pre_w[(g == 0) ? 0 : g - 1]),
			.suf_in    ((g == CAPACITY - 1) ? 1'b0 : suf_w[(g == CAPACITY - 1) ? g : g + 1]),
			.elem      (elem_w[g]),
			.ge        (ge_w[g]),
			.pre_out   (pre_w[g]),
			.suf_out   (suf_w[g])
		);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bole_pkg::ST_IDLE: begin
				if (in_valid) state_nx = bole_pkg::ST_CMP;
			end
			bole_pkg::ST_CMP: begin
				state_nx = bole_pkg::ST_APPLY;
			end
			bole_pkg::ST_APPLY: begin
				if (can_emit) begin
					if (cmd_q.cmd == bole_pkg::CMD_READ && !empty && len_q != LW'(1))
						state_nx = bole_pkg::ST_READ;
					else
						state_nx = bole_pkg::ST_IDLE;
				end
			end
			bole_pkg::ST_READ: begin
				if (can_emit && cnt_q == len_q - LW'(1)) state_nx = bole_pkg::ST_IDLE;
			end
			default: state_nx = bole_pkg::ST_IDLE;
		endcase
	end

	// cell control, result and list bookkeeping
	always_comb begin
		ctl.op     = bole_pkg::OP_HOLD;
		ctl.ge_sel = bole_pkg::GE_ALL;
		ctl.value  = cmd_q.value;
		ctl.wrap   = rev_q ? tail : head;
		ctl.len    = len_q;
		len_nx     = len_q;
		rev_nx     = rev_q;
		emit       = 1'b0;
		res.status      = bole_pkg::STAT_OK;
		res.found       = 1'b0;
		res.element     = '0;
		res.last_of_run = 1'b1;
		unique case (state_q)
			bole_pkg::ST_APPLY: begin
				emit = can_emit;
				case (cmd_q.cmd) inside
					bole_pkg::CMD_SET: begin
						ctl.op = bole_pkg::OP_SET0;
						len_nx = LW'(1);
						rev_nx = 1'b0;
					end
					bole_pkg::CMD_FRONT, bole_pkg::CMD_END: begin
						if (full) begin
							res.status = bole_pkg::STAT_FULL;
						end else begin
							ctl.op     = bole_pkg::OP_INS;
							ctl.ge_sel = ((cmd_q.cmd == bole_pkg::CMD_FRONT) != rev_q)
								? bole_pkg::GE_ALL : bole_pkg::GE_TAIL;
							len_nx     = len_q + LW'(1);
						end
					end
					bole_pkg::CMD_AFTER, bole_pkg::CMD_BEFORE: begin
						if (empty) begin
							res.status = bole_pkg::STAT_EMPTY;
						end else if (full) begin
							res.status = bole_pkg::STAT_FULL;
						end else if (!any_match) begin
							res.status = bole_pkg::STAT_NOT_FOUND;
						end else begin
							ctl.op = bole_pkg::OP_INS;
							if (cmd_q.cmd == bole_pkg::CMD_AFTER)
								ctl.ge_sel = rev_q ? bole_pkg::GE_NSUF : bole_pkg::GE_PRE;
							else
								ctl.ge_sel = rev_q ? bole_pkg::GE_NSUF_INCL
									: bole_pkg::GE_PRE_INCL;
							len_nx = len_q + LW'(1);
						end
					end
					bole_pkg::CMD_DEL: begin
						if (empty) begin
							res.status = bole_pkg::STAT_EMPTY;
						end else if (!any_match) begin
							res.status = bole_pkg::STAT_NOT_FOUND;
						end else begin
							ctl.op     = bole_pkg::OP_DEL;
							ctl.ge_sel = rev_q ? bole_pkg::GE_NSUF : bole_pkg::GE_PRE_INCL;
							len_nx     = len_q - LW'(1);
						end
					end
					bole_pkg::CMD_REV: begin
						if (empty) res.status = bole_pkg::STAT_EMPTY;
						else       rev_nx = !rev_q;
					end
					bole_pkg::CMD_SEARCH: begin
						if (empty)          res.status = bole_pkg::STAT_EMPTY;
						else if (any_match) res.found = 1'b1;
						else                res.status = bole_pkg::STAT_NOT_FOUND;
					end
					bole_pkg::CMD_READ: begin
						if (empty) begin
							res.status = bole_pkg::STAT_EMPTY;
						end else begin
							ctl.op          = rev_q ? bole_pkg::OP_ROT_UP : bole_pkg::OP_ROT_DN;
							res.element     = rev_q ? tail : head;
							res.last_of_run = len_q == LW'(1);
						end
					end
					default: begin
					end
				endcase
				if (!can_emit) begin
					ctl.op = bole_pkg::OP_HOLD;
					len_nx = len_q;
					rev_nx = rev_q;
				end
			end
			bole_pkg::ST_READ: begin
				emit            = can_emit;
				res.element     = rev_q ? tail : head;
				res.last_of_run = cnt_q == len_q - LW'(1);
				if (can_emit) ctl.op = rev_q ? bole_pkg::OP_ROT_UP : bole_pkg::OP_ROT_DN;
			end
			default: begin
			end
		endcase
		res.count = len_nx;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bole_pkg::ST_IDLE;
			len_q       <= '0;
			rev_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			len_q   <= len_nx;
			rev_q   <= rev_nx;
			if (state_q == bole_pkg::ST_APPLY) cnt_q <= LW'(1);
			else if (state_q == bole_pkg::ST_READ && can_emit) cnt_q <= cnt_q + LW'(1);
			if (emit)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// hold the command and the result beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) cmd_q <= in_data;
		if (emit) out_q <= res;
	end

endmodule

[rtl/bole_cell.sv]
`timescale 1ns / 1ps
module bole_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bole_pkg::cell_ctl_t         ctl,
	input  logic [bole_pkg::DATA_W-1:0] cmp_x,
	input  logic [bole_pkg::DATA_W-1:0] left_elem,
	input  logic                        left_ge,
	input  logic [bole_pkg::DATA_W-1:0] right_elem,
	input  logic                        pre_in,
	input  logic                        suf_in,
	output logic [bole_pkg::DATA_W-1:0] elem,
	output logic                        ge,
	output logic                        pre_out,
	output logic                        suf_out
);

	logic [bole_pkg::DATA_W-1:0] elem_q;
	logic                        match_q;
	logic                        valid;
	logic                        is_last;

	assign valid   = ctl.len > bole_pkg::LEN_W'(IDX);
	assign is_last = ctl.len == bole_pkg::LEN_W'(IDX + 1);
	assign elem    = elem_q;

	// pass match summaries along the row in both directions
	assign pre_out = pre_in | match_q;
	assign suf_out = suf_in | match_q;

	// decide whether this cell lies at or above the edit position
	always_comb begin
		case (ctl.ge_sel)
			bole_pkg::GE_ALL:       ge = 1'b1;
			bole_pkg::GE_TAIL:      ge = !valid;
			bole_pkg::GE_PRE:       ge = pre_in;
			bole_pkg::GE_PRE_INCL:  ge = pre_in | match_q;
			bole_pkg::GE_NSUF:      ge = !suf_in;
			bole_pkg::GE_NSUF_INCL: ge = !(suf_in | match_q);
			default:                ge = 1'b0;
		endcase
	end

	// register the compare against the held search value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= valid && (elem_q == cmp_x);
		end
	end

	// set, shift, insert, drop or rotate the stored element
	always_ff @(posedge clk) begin
		case (ctl.op)
			bole_pkg::OP_SET0: begin
				if (IDX == 0) elem_q <= ctl.value;
			end
			bole_pkg::OP_INS: begin
				if (ge) elem_q <= left_ge ? left_elem : ctl.value;
			end
			bole_pkg::OP_DEL: begin
				if (ge) elem_q <= right_elem;
			end
			bole_pkg::OP_ROT_DN: begin
				elem_q <= is_last ? ctl.wrap : right_elem;
			end
			bole_pkg::OP_ROT_UP: begin
				elem_q <= (IDX == 0) ? ctl.wrap : left_elem;
			end
			default: begin
				elem_q <= elem_q;
			end
		endcase
	end

endmodule

[dv/bounded_ordered_list_engine_top_tb.sv]
`timescale 1ns / 1ps
module bounded_ordered_list_engine_top_tb;

	localparam int CAP = bole_pkg::CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	bole_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	bole_pkg::out_t out_data;

	bounded_ordered_list_engine_top #(.CAPACITY(CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// model of the list contents
	logic signed [31:0] list_mem[CAP];
	int list_len;

	bole_pkg::in_t cmd_q[$];
	bole_pkg::out_t beat_q[$];
	int mismatches;
	int idle_cycles;
	int send_gap;
	int recv_gap;
	bit hold_off;
	bit hold_done;
	int hold_left;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int first_index(logic signed [31:0] v);
		for (int i = 0; i < list_len; i++)
			if (list_mem[i] == v) return i;
		return -1;
	endfunction

	task automatic list_insert(int pos, logic signed [31:0] v);
		for (int i = list_len; i > pos; i--)
			list_mem[i] = list_mem[i-1];
		list_mem[pos] = v;
		list_len++;
	endtask

	task automatic push_beat(bole_pkg::status_e st, logic fnd, logic signed [31:0] el,
		logic last);
		bole_pkg::out_t b;
		b.status = st;
		b.found = fnd;
		b.count = list_len[6:0];
		b.element = el;
		b.last_of_run = last;
		beat_q.push_back(b);
	endtask

	// work out the beats that one accepted command causes
	task automatic predict_list_op(bole_pkg::in_t c);
		bole_pkg::status_e st;
		logic fnd;
		int pos;
		logic signed [31:0] t;
		st = bole_pkg::STAT_OK;
		fnd = 1'b0;
		case (c.cmd)
			bole_pkg::CMD_SET: begin
				list_mem[0] = c.value;
				list_len = 1;
			end
			bole_pkg::CMD_FRONT, bole_pkg::CMD_END: begin
				if (list_len >= CAP) st = bole_pkg::STAT_FULL;
				else list_insert((c.cmd == bole_pkg::CMD_FRONT) ? 0 : list_len, c.value);
			end
			bole_pkg::CMD_AFTER, bole_pkg::CMD_BEFORE: begin
				if (list_len == 0) st = bole_pkg::STAT_EMPTY;
				else if (list_len >= CAP) st = bole_pkg::STAT_FULL;
				else begin
					pos = first_index(c.key);
					if (pos < 0) st = bole_pkg::STAT_NOT_FOUND;
					else list_insert(pos + ((c.cmd == bole_pkg::CMD_AFTER) ? 1 : 0), c.value);
				end
			end
			bole_pkg::CMD_DEL: begin
				if (list_len == 0) st = bole_pkg::STAT_EMPTY;
				else begin
					pos = first_index(c.value);
					if (pos < 0) st = bole_pkg::STAT_NOT_FOUND;
					else begin
						for (int i = pos; i + 1 < list_len; i++)
							list_mem[i] = list_mem[i+1];
						list_len--;
					end
				end
			end
			bole_pkg::CMD_REV: begin
				if (list_len == 0) st = bole_pkg::STAT_EMPTY;
				else
					for (int i = 0; i < list_len / 2; i++) begin
						t = list_mem[i];
						list_mem[i] = list_mem[list_len - 1 - i];
						list_mem[list_len - 1 - i] = t;
					end
			end
			bole_pkg::CMD_SEARCH: begin
				if (list_len == 0) st = bole_pkg::STAT_EMPTY;
				else if (first_index(c.value) >= 0) fnd = 1'b1;
				else st = bole_pkg::STAT_NOT_FOUND;
			end
			bole_pkg::CMD_READ: begin
				if (list_len == 0) st = bole_pkg::STAT_EMPTY;
				else begin
					for (int i = 0; i < list_len; i++)
						push_beat(bole_pkg::STAT_OK, 1'b0, list_mem[i], (i + 1 == list_len));
					return;
				end
			end
			default: ;
		endcase
		push_beat(st, fnd, 32'sd0, 1'b1);
	endtask

	function automatic bole_pkg::in_t mk(logic [3:0] c, logic signed [31:0] v,
		logic signed [31:0] k);
		bole_pkg::in_t x;
		x.cmd = c;
		x.value = v;
		x.key = k;
		return x;
	endfunction

	// pick a value from a small pool most of the time so keys hit
	function automatic logic signed [31:0] rnd_val();
		if ($urandom_range(0, 3) != 0) return $signed($urandom_range(0, 15)) - 8;
		return $signed($urandom());
	endfunction

	// driver: offer queued commands, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
			list_len = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_list_op(in_data);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					in_data <= cmd_q.pop_front();
					in_valid <= 1'b1;
					send_gap <= gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (hold_off && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 300;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 2) == 0) recv_gap <= gap_len();
			end
		end
	end

	// monitor: compare each beat with the oldest expected beat
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
			mismatches = 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (beat_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected beat %p", out_data);
				end else if (out_data !== beat_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", beat_q[0], out_data);
					void'(beat_q.pop_front());
				end else begin
					void'(beat_q.pop_front());
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [3:0] c;
		int r;
		arst_n = 1'b0;
		hold_off = 1'b0;
		// directed: empty-list cases, extremes, every command
		cmd_q.push_back(mk(bole_pkg::CMD_READ, 0, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_DEL, 1, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_REV, 0, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_SEARCH, 1, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_AFTER, 1, 1));
		cmd_q.push_back(mk(bole_pkg::CMD_BEFORE, 1, 1));
		cmd_q.push_back(mk(bole_pkg::CMD_FRONT, 32'sh7fffffff, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_END, 32'sh80000000, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_AFTER, -1, 32'sh7fffffff));
		cmd_q.push_back(mk(bole_pkg::CMD_BEFORE, 0, 32'sh80000000));
		cmd_q.push_back(mk(bole_pkg::CMD_AFTER, 5, 12345));
		cmd_q.push_back(mk(bole_pkg::CMD_READ, 0, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_REV, 0, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_READ, 0, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_SEARCH, -1, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_SEARCH, 99, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_DEL, 99, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_DEL, 32'sh80000000, 0));
		cmd_q.push_back(mk(4'd9, 0, 0));
		cmd_q.push_back(mk(4'd15, -1, -1));
		cmd_q.push_back(mk(bole_pkg::CMD_SET, -1, -1));
		// fill to capacity, then try every insert on a full list
		for (int i = 0; i < CAP - 1; i++) cmd_q.push_back(mk(bole_pkg::CMD_END, i, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_FRONT, 1, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_END, 1, 0));
		cmd_q.push_back(mk(bole_pkg::CMD_AFTER, 1, 1));
		cmd_q.push_back(mk(bole_pkg::CMD_BEFORE, 1, 1));
		cmd_q.push_back(mk(bole_pkg::CMD_READ, 0, 0));
		// random part
		for (int i = 0; i < 210; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) c = bole_pkg::CMD_SET;
			else if (r < 18) c = bole_pkg::CMD_FRONT;
			else if (r < 33) c = bole_pkg::CMD_END;
			else if (r < 45) c = bole_pkg::CMD_AFTER;
			else if (r < 57) c = bole_pkg::CMD_BEFORE;
			else if (r < 72) c = bole_pkg::CMD_DEL;
			else if (r < 78) c = bole_pkg::CMD_REV;
			else if (r < 88) c = bole_pkg::CMD_SEARCH;
			else if (r < 96) c = bole_pkg::CMD_READ;
			else c = 4'($urandom_range(9, 15));
			cmd_q.push_back(mk(c, rnd_val(), rnd_val()));
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// long receiver hold-off while commands keep coming
		wait (cmd_q.size() < 200);
		@(posedge clk);
		hold_off <= 1'b1;
		wait (cmd_q.size() == 0 && !in_valid);
		wait (beat_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && beat_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
